// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, outside reset.
`define TCMC_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds on a rising edge, outside reset.
`define TCMC_NEVER(name, clk, rst_n, cond, msg) \
  `TCMC_ASSERT(name, clk, rst_n, !(cond), msg)

`endif

// ----- src/tcmc_pkg.sv -----
// Shared types, constants and word table of the text command motor controller.
package tcmc_pkg;

  // Command codes in table order; unknown text takes the last code.
  typedef enum logic [3:0] {
    CMD_START    = 4'd0,
    CMD_STOP     = 4'd1,
    CMD_FORWARD  = 4'd2,
    CMD_REVERSE  = 4'd3,
    CMD_ZERO     = 4'd4,
    CMD_FIRST    = 4'd5,
    CMD_SECOND   = 4'd6,
    CMD_THIRST   = 4'd7,
    CMD_THOURTH  = 4'd8,
    CMD_FOURTH   = 4'd9,
    CMD_UNKNOWN  = 4'd10
  } cmd_e;

  localparam int unsigned NumWords  = 10;
  localparam int unsigned WordBytes = 16;
  localparam int unsigned PosW      = 7;
  localparam logic [7:0]  Terminator = 8'h3B;
  localparam logic [2:0]  TopSpeed   = 3'd4;

  // Command words, left aligned and padded with zero bytes.
  localparam logic [WordBytes*8-1:0] WordTable [NumWords] = '{
    {"start",              88'h0},
    {"stop",               96'h0},
    {"forward",            72'h0},
    {"reverse",            72'h0},
    {"zero",    "_speed",  48'h0},
    {"first",   "_speed",  40'h0},
    {"second",  "_speed",  32'h0},
    {"thirst",  "_speed",  32'h0},
    {"thourth", "_speed",  24'h0},
    {"fourth",  "_speed",  32'h0}
  };

  // Character of a command word at a position; zero past its end.
  function automatic logic [7:0] word_char(input int unsigned widx,
                                           input logic [PosW-1:0] pos);
    logic [7:0] res;
    int unsigned sh;
    res = 8'h00;
    sh  = 0;
    if (int'(pos) < int'(WordBytes)) begin
      sh  = 8 * (WordBytes - 1 - int'(pos));
      res = WordTable[widx][sh +: 8];
    end
    return res;
  endfunction

  // One-hot speed select; zero at speed 0.
  function automatic logic [3:0] speed_onehot(input logic [2:0] lvl);
    logic [3:0] res;
    res = 4'b0000;
    if (lvl >= 3'd1 && lvl <= TopSpeed) begin
      res = 4'b0001 << (lvl - 3'd1);
    end
    return res;
  endfunction

endpackage

// ----- src/tcmc_ram.sv -----
// Generic single write port RAM with registered read.
module tcmc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 15
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write on enable, register read data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/text_command_motor_controller_core.sv -----
// Text command motor controller: stores received text, decodes it on ';', ramps speed.
// An ordinary byte is stored while room is left and gives no result.
// A terminator starts a scan that compares the stored bytes up to the first zero (one read a cycle),
// then gives up to four pulse items and one status item, one a cycle while out_ready_i.
// The next byte is accepted the cycle after the status item is registered.
// Reset clears flags, speed and text length; the text memory is not cleared.
module text_command_motor_controller_core #(
  parameter int unsigned MAX_TEXT = 15
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       step_up_o,
  output logic       step_down_o,
  output logic       drive_forward_o,
  output logic       drive_reverse_o,
  output logic [3:0] speed_lines_o,
  output logic [3:0] command_code_o,
  output logic       last_o
);

  localparam int unsigned LenW  = $clog2(MAX_TEXT + 1);
  localparam int unsigned AddrW = $clog2(MAX_TEXT);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_e;

  state_e                        state_q, state_d;
  logic [LenW-1:0]               len_q, len_d;
  logic [LenW-1:0]               iss_idx_q, iss_idx_d;
  logic [LenW-1:0]               cmp_idx_q, cmp_idx_d;
  logic                          rd_pend_q, rd_pend_d;
  logic [tcmc_pkg::NumWords-1:0] match_q, match_d;
  tcmc_pkg::cmd_e                code_q, code_d;
  logic                          tgt_valid_q, tgt_valid_d;
  logic [2:0]                    tgt_q, tgt_d;
  logic [3:0]                    old_lines_q, old_lines_d;
  logic                          running_q, running_d;
  logic                          reversed_q, reversed_d;
  logic [2:0]                    speed_q, speed_d;
  logic                          out_valid_q, out_valid_d;
  logic                          step_up_q, step_up_d;
  logic                          step_down_q, step_down_d;
  logic                          fwd_q, fwd_d;
  logic                          rev_q, rev_d;
  logic [3:0]                    lines_q, lines_d;
  logic [3:0]                    out_code_q, out_code_d;
  logic                          last_q, last_d;

  logic                          ram_we;
  logic                          ram_re;
  logic [7:0]                    ram_rdata;
  logic [tcmc_pkg::NumWords-1:0] char_hit;
  logic [tcmc_pkg::NumWords-1:0] final_hit;
  tcmc_pkg::cmd_e                found_code;
  logic                          scan_done;
  logic                          out_free;
  logic                          run_next;

  // Text memory: written from the input, read back during the scan.
  tcmc_ram #(
    .Width (8),
    .Depth (MAX_TEXT)
  ) u_text_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (len_q[AddrW-1:0]),
    .wdata_i (rx_byte_i),
    .re_i    (ram_re),
    .raddr_i (iss_idx_q[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Compare the byte under test against every word, pick the first full match.
  always_comb begin
    found_code = tcmc_pkg::CMD_UNKNOWN;
    for (int unsigned w = 0; w < tcmc_pkg::NumWords; w++) begin
      char_hit[w]  = tcmc_pkg::word_char(w, tcmc_pkg::PosW'(cmp_idx_q)) == ram_rdata;
      final_hit[w] = match_q[w] &&
                     (tcmc_pkg::word_char(w, tcmc_pkg::PosW'(cmp_idx_q)) == 8'h00);
    end
    for (int w = tcmc_pkg::NumWords - 1; w >= 0; w--) begin
      if (final_hit[w]) begin
        found_code = tcmc_pkg::cmd_e'(4'(w));
      end
    end
  end

  assign scan_done = (rd_pend_q && ram_rdata == 8'h00) ||
                     (!rd_pend_q && cmp_idx_q == len_q);
  assign out_free  = !out_valid_q || out_ready_i;
  assign run_next  = (code_q == tcmc_pkg::CMD_STOP) ? 1'b0 : running_q;

  // Next state: store, scan, then emit pulses and status.
  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    iss_idx_d   = iss_idx_q;
    cmp_idx_d   = cmp_idx_q;
    rd_pend_d   = rd_pend_q;
    match_d     = match_q;
    code_d      = code_q;
    tgt_valid_d = tgt_valid_q;
    tgt_d       = tgt_q;
    old_lines_d = old_lines_q;
    running_d   = running_q;
    reversed_d  = reversed_q;
    speed_d     = speed_q;
    out_valid_d = out_valid_q;
    step_up_d   = step_up_q;
    step_down_d = step_down_q;
    fwd_d       = fwd_q;
    rev_d       = rev_q;
    lines_d     = lines_q;
    out_code_d  = out_code_q;
    last_d      = last_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;

    // Drop the output item once taken.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (rx_byte_i == tcmc_pkg::Terminator) begin
            iss_idx_d = '0;
            cmp_idx_d = '0;
            rd_pend_d = 1'b0;
            match_d   = '1;
            state_d   = ST_SCAN;
          end else if (len_q < LenW'(MAX_TEXT)) begin
            ram_we = 1'b1;
            len_d  = len_q + LenW'(1);
          end
        end
      end

      ST_SCAN: begin
        if (scan_done) begin
          // Decode and apply the command.
          code_d      = found_code;
          len_d       = '0;
          rd_pend_d   = 1'b0;
          old_lines_d = tcmc_pkg::speed_onehot(speed_q);
          tgt_valid_d = 1'b0;
          tgt_d       = 3'd0;
          case (found_code)
            tcmc_pkg::CMD_START:   running_d = 1'b1;
            tcmc_pkg::CMD_STOP:    tgt_valid_d = 1'b1;
            tcmc_pkg::CMD_FORWARD: reversed_d = 1'b0;
            tcmc_pkg::CMD_REVERSE: reversed_d = 1'b1;
            tcmc_pkg::CMD_ZERO:    tgt_valid_d = 1'b1;
            tcmc_pkg::CMD_FIRST: begin
              tgt_valid_d = 1'b1;
              tgt_d       = 3'd1;
            end
            tcmc_pkg::CMD_SECOND: begin
              tgt_valid_d = 1'b1;
              tgt_d       = 3'd2;
            end
            tcmc_pkg::CMD_THIRST: begin
              tgt_valid_d = 1'b1;
              tgt_d       = 3'd3;
            end
            tcmc_pkg::CMD_FOURTH: begin
              tgt_valid_d = 1'b1;
              tgt_d       = tcmc_pkg::TopSpeed;
            end
            default: begin
            end
          endcase
          state_d = ST_EMIT;
        end else begin
          // Compare the returned byte, issue the next read.
          if (rd_pend_q) begin
            match_d   = match_q & char_hit;
            cmp_idx_d = cmp_idx_q + LenW'(1);
          end
          if (iss_idx_q < len_q) begin
            ram_re    = 1'b1;
            iss_idx_d = iss_idx_q + LenW'(1);
            rd_pend_d = 1'b1;
          end else begin
            rd_pend_d = 1'b0;
          end
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_code_d  = code_q;
          rev_d       = reversed_q;
          if (tgt_valid_q && speed_q != tgt_q) begin
            // Pulse item: one speed step.
            step_up_d   = speed_q < tgt_q;
            step_down_d = speed_q > tgt_q;
            speed_d     = (speed_q > tgt_q) ? speed_q - 3'd1 : speed_q + 3'd1;
            fwd_d       = running_q && !reversed_q;
            rev_d       = running_q && reversed_q;
            lines_d     = old_lines_q;
            last_d      = 1'b0;
          end else begin
            // Status item closes the command.
            running_d   = run_next;
            step_up_d   = 1'b0;
            step_down_d = 1'b0;
            fwd_d       = run_next && !reversed_q;
            rev_d       = run_next && reversed_q;
            lines_d     = tcmc_pkg::speed_onehot(speed_q);
            last_d      = 1'b1;
            state_d     = ST_IDLE;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Hold state, flags and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      iss_idx_q   <= '0;
      cmp_idx_q   <= '0;
      rd_pend_q   <= 1'b0;
      match_q     <= '0;
      code_q      <= tcmc_pkg::CMD_UNKNOWN;
      tgt_valid_q <= 1'b0;
      tgt_q       <= 3'd0;
      old_lines_q <= 4'd0;
      running_q   <= 1'b0;
      reversed_q  <= 1'b0;
      speed_q     <= 3'd0;
      out_valid_q <= 1'b0;
      step_up_q   <= 1'b0;
      step_down_q <= 1'b0;
      fwd_q       <= 1'b0;
      rev_q       <= 1'b0;
      lines_q     <= 4'd0;
      out_code_q  <= 4'd0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      iss_idx_q   <= iss_idx_d;
      cmp_idx_q   <= cmp_idx_d;
      rd_pend_q   <= rd_pend_d;
      match_q     <= match_d;
      code_q      <= code_d;
      tgt_valid_q <= tgt_valid_d;
      tgt_q       <= tgt_d;
      old_lines_q <= old_lines_d;
      running_q   <= running_d;
      reversed_q  <= reversed_d;
      speed_q     <= speed_d;
      out_valid_q <= out_valid_d;
      step_up_q   <= step_up_d;
      step_down_q <= step_down_d;
      fwd_q       <= fwd_d;
      rev_q       <= rev_d;
      lines_q     <= lines_d;
      out_code_q  <= out_code_d;
      last_q      <= last_d;
    end
  end

  assign in_ready_o      = state_q == ST_IDLE;
  assign out_valid_o     = out_valid_q;
  assign step_up_o       = step_up_q;
  assign step_down_o     = step_down_q;
  assign drive_forward_o = fwd_q;
  assign drive_reverse_o = rev_q;
  assign speed_lines_o   = lines_q;
  assign command_code_o  = out_code_q;
  assign last_o          = last_q;

endmodule

// ----- src/tcmc_checker.sv -----
// Port-level checker for the text command motor controller, bound to the controller core.
`include "assert_macros.svh"

module tcmc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] rx_byte_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       step_up_o,
  input logic       step_down_o,
  input logic       drive_forward_o,
  input logic       drive_reverse_o,
  input logic [3:0] speed_lines_o,
  input logic [3:0] command_code_o,
  input logic       last_o
);

  // A stalled item keeps its fields.
  `TCMC_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable({step_up_o, step_down_o, drive_forward_o, drive_reverse_o, speed_lines_o, command_code_o, last_o}), "output item changed while stalled")

  // Both drive lines never on together.
  `TCMC_NEVER(a_drive_excl, clk_i, rst_ni, out_valid_o && drive_forward_o && drive_reverse_o, "forward and reverse driven together")

  // A status item carries no pulse, a pulse item is never up and down.
  `TCMC_NEVER(a_last_pulse, clk_i, rst_ni, out_valid_o && last_o && (step_up_o || step_down_o), "status item carries a pulse")

  `TCMC_NEVER(a_pulse_excl, clk_i, rst_ni, out_valid_o && step_up_o && step_down_o, "up and down pulse together")

  // Speed select stays one-hot or zero.
  `TCMC_ASSERT(a_lines_onehot, clk_i, rst_ni, out_valid_o |-> $onehot0(speed_lines_o), "speed lines not one-hot")

endmodule

bind text_command_motor_controller_core tcmc_checker u_tcmc_checker (.*);

// ----- verif/testbench.sv -----
// Self-checking testbench for the text command motor controller core.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned TEXT_DEPTH  = 15;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned SETTLE_WAIT = 40;

  // One status or pulse item as the block presents it
  typedef struct packed {
    logic           step_up;
    logic           step_down;
    logic           fwd;
    logic           rev;
    logic [3:0]     lines;
    tcmc_pkg::cmd_e code;
    logic           last;
  } motor_report_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic [7:0] rx_byte_i = 8'h00;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic       step_up_o;
  logic       step_down_o;
  logic       drive_forward_o;
  logic       drive_reverse_o;
  logic [3:0] speed_lines_o;
  logic [3:0] command_code_o;
  logic       last_o;

  // Mirror of the block state
  logic [7:0]  text_mem [TEXT_DEPTH];
  int unsigned text_len = 0;
  logic        motor_on = 1'b0;
  logic        dir_reversed = 1'b0;
  logic [2:0]  speed_level = 3'd0;

  motor_report_t expected_reports[$];
  motor_report_t want;

  string command_words[10];

  // Run bookkeeping
  int unsigned fail_count = 0;
  int unsigned bytes_taken = 0;
  int unsigned commands_seen = 0;
  int unsigned unknown_seen = 0;
  int unsigned steps_seen = 0;
  int unsigned reports_checked = 0;
  int unsigned longest_hold = 0;

  // Idling controls and long hold-off handshake between sender and receiver
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;
  int unsigned hold_run = 0;

  text_command_motor_controller_core #(
    .MAX_TEXT(TEXT_DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .step_up_o      (step_up_o),
    .step_down_o    (step_down_o),
    .drive_forward_o(drive_forward_o),
    .drive_reverse_o(drive_reverse_o),
    .speed_lines_o  (speed_lines_o),
    .command_code_o (command_code_o),
    .last_o         (last_o)
  );

  always #6 clk_i = ~clk_i;

  // Fill the command word list in code order
  function automatic void load_words();
    string tail;
    tail = "_speed";
    command_words[tcmc_pkg::CMD_START]   = "start";
    command_words[tcmc_pkg::CMD_STOP]    = "stop";
    command_words[tcmc_pkg::CMD_FORWARD] = "forward";
    command_words[tcmc_pkg::CMD_REVERSE] = "reverse";
    command_words[tcmc_pkg::CMD_ZERO]    = {"zero", tail};
    command_words[tcmc_pkg::CMD_FIRST]   = {"first", tail};
    command_words[tcmc_pkg::CMD_SECOND]  = {"second", tail};
    command_words[tcmc_pkg::CMD_THIRST]  = {"thirst", tail};
    command_words[tcmc_pkg::CMD_THOURTH] = {"thourth", tail};
    command_words[tcmc_pkg::CMD_FOURTH]  = {"fourth", tail};
  endfunction

  // One-hot speed select, zero at standstill
  function automatic logic [3:0] lines_for(input logic [2:0] lvl);
    if (lvl == 3'd0) return 4'b0000;
    return 4'(1 << (lvl - 3'd1));
  endfunction

  // Queue one expected item with the drive levels now in force
  function automatic void queue_report(input logic up, input logic down,
                                       input logic [3:0] lines,
                                       input tcmc_pkg::cmd_e code,
                                       input logic last);
    motor_report_t rep;
    rep.step_up   = up;
    rep.step_down = down;
    rep.fwd       = motor_on && !dir_reversed;
    rep.rev       = motor_on && dir_reversed;
    rep.lines     = lines;
    rep.code      = code;
    rep.last      = last;
    expected_reports.push_back(rep);
  endfunction

  // Store a character or decode the stored text and predict the items it causes
  function automatic void predict_reports(input logic [7:0] value);
    int unsigned    used;
    tcmc_pkg::cmd_e code;
    int             target;
    logic [3:0]     lines_before;
    bit             same;
    if (value != tcmc_pkg::Terminator) begin
      if (text_len < TEXT_DEPTH) begin
        text_mem[text_len] = value;
        text_len++;
        bytes_taken++;
      end
      return;
    end
    bytes_taken++;
    commands_seen++;
    // Cut the text at its first zero byte
    used = 0;
    while (used < text_len && text_mem[used] != 8'h00) used++;
    code = tcmc_pkg::CMD_UNKNOWN;
    for (int w = 0; w < 10; w++) begin
      if (code == tcmc_pkg::CMD_UNKNOWN && command_words[w].len() == used) begin
        same = 1'b1;
        for (int i = 0; i < used; i++) begin
          if (command_words[w][i] != text_mem[i]) same = 1'b0;
        end
        if (same) code = tcmc_pkg::cmd_e'(w);
      end
    end
    if (code == tcmc_pkg::CMD_UNKNOWN) unknown_seen++;
    text_len = 0;
    lines_before = lines_for(speed_level);
    target = -1;
    case (code)
      tcmc_pkg::CMD_START:   motor_on = 1'b1;
      tcmc_pkg::CMD_STOP,
      tcmc_pkg::CMD_ZERO:    target = 0;
      tcmc_pkg::CMD_FORWARD: dir_reversed = 1'b0;
      tcmc_pkg::CMD_REVERSE: dir_reversed = 1'b1;
      tcmc_pkg::CMD_FIRST:   target = 1;
      tcmc_pkg::CMD_SECOND:  target = 2;
      tcmc_pkg::CMD_THIRST:  target = 3;
      tcmc_pkg::CMD_FOURTH:  target = int'(tcmc_pkg::TopSpeed);
      default:               ;
    endcase
    // Ramp one step per pulse item; lines hold their old value until the end
    if (target >= 0) begin
      while (int'(speed_level) > target) begin
        queue_report(1'b0, 1'b1, lines_before, code, 1'b0);
        speed_level--;
        steps_seen++;
      end
      while (int'(speed_level) < target) begin
        queue_report(1'b1, 1'b0, lines_before, code, 1'b0);
        speed_level++;
        steps_seen++;
      end
      if (code == tcmc_pkg::CMD_STOP) motor_on = 1'b0;
    end
    queue_report(1'b0, 1'b0, lines_for(speed_level), code, 1'b1);
  endfunction

  function automatic void check_field(input string name, input logic [3:0] exp_v,
                                      input logic [3:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      fail_count++;
    end
  endfunction

  // Offer one character, with an optional idle burst first, and wait for acceptance
  task automatic send_byte(input logic [7:0] value);
    int unsigned gap;
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      rx_byte_i  <= 8'($urandom);
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    rx_byte_i  <= value;
    do @(posedge clk_i); while (!in_ready_o);
    predict_reports(value);
  endtask

  task automatic send_command(input string text);
    for (int i = 0; i < text.len(); i++) send_byte(text[i]);
    send_byte(tcmc_pkg::Terminator);
  endtask

  // Drop valid and hold until every expected item has come back
  task automatic pause_until_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
  endtask

  // Mostly well-formed words with random damage now and then
  task automatic send_random_command();
    logic [7:0]  line[$];
    string       word;
    int unsigned kind;
    int unsigned pos;
    word = command_words[$urandom_range(0, 9)];
    kind = $urandom_range(0, 99);
    for (int i = 0; i < word.len(); i++) line.push_back(word[i]);
    if (kind < 10) begin
      pos = $urandom_range(0, line.size() - 1);
      line[pos] = 8'($urandom_range(0, 255));
    end else if (kind < 15) begin
      void'(line.pop_back());
    end else if (kind < 20) begin
      line.push_back(8'($urandom_range(33, 126)));
    end else if (kind < 27) begin
      line.push_back(8'h00);
      repeat ($urandom_range(0, 4)) line.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 32) begin
      line.delete();
      repeat ($urandom_range(16, 24)) line.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 37) begin
      line.delete();
      repeat ($urandom_range(0, 15)) line.push_back(8'($urandom_range(0, 255)));
    end
    foreach (line[i]) send_byte(line[i]);
    send_byte(tcmc_pkg::Terminator);
  endtask

  // Every command word, redundant commands and full-range ramps
  task automatic test_command_words();
    send_command(command_words[tcmc_pkg::CMD_FIRST]);
    send_command("start");
    send_command("start");
    send_command("forward");
    send_command(command_words[tcmc_pkg::CMD_FOURTH]);
    send_command("reverse");
    send_command("reverse");
    send_command(command_words[tcmc_pkg::CMD_SECOND]);
    send_command(command_words[tcmc_pkg::CMD_THIRST]);
    send_command(command_words[tcmc_pkg::CMD_THOURTH]);
    send_command(command_words[tcmc_pkg::CMD_ZERO]);
    send_command(command_words[tcmc_pkg::CMD_FOURTH]);
    send_command("forward");
    send_command("stop");
    send_command("stop");
  endtask

  // Empty text, zero bytes, overlong text and near misses
  task automatic test_odd_text();
    send_byte(tcmc_pkg::Terminator);
    send_byte(8'h00);
    send_byte(tcmc_pkg::Terminator);
    send_command("start");
    for (int i = 0; i < 12; i++) send_byte(command_words[tcmc_pkg::CMD_SECOND][i]);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(tcmc_pkg::Terminator);
    for (int i = 0; i < 11; i++) send_byte(command_words[tcmc_pkg::CMD_FIRST][i]);
    repeat (9) send_byte(8'hFF);
    send_byte(tcmc_pkg::Terminator);
    send_command({command_words[tcmc_pkg::CMD_THOURTH], "AB"});
    send_command("Stop");
    send_command("start ");
    send_command("stop");
  endtask

  // Hold the output for a long stretch while commands keep arriving
  task automatic test_output_backpressure();
    hold_requests++;
    send_command(command_words[tcmc_pkg::CMD_FOURTH]);
    send_command("reverse");
    send_command("stop");
    send_command("start");
    send_command(command_words[tcmc_pkg::CMD_FIRST]);
    pause_until_drained();
  endtask

  task automatic test_random_traffic();
    int unsigned goal;
    goal = bytes_taken + 110;
    while (bytes_taken < goal) send_random_command();
  endtask

  // Finish with both sides running flat out
  task automatic test_closing_burst();
    int unsigned goal;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    goal = bytes_taken + 45;
    while (bytes_taken < goal) send_random_command();
  endtask

  // Receiver: random stall bursts, plus the long hold-off on request
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
      hold_run    <= hold_run + 1;
    end else if (holds_served != hold_requests) begin
      holds_served <= hold_requests;
      out_ready_i  <= 1'b0;
      hold_left    <= LONG_HOLD - 1;
      hold_run     <= 1;
    end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= $urandom_range(0, 16);
      hold_run    <= 1;
    end else begin
      out_ready_i <= 1'b1;
      if (hold_run > longest_hold) longest_hold <= hold_run;
      hold_run <= 0;
    end
  end

  // Compare each accepted item with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_reports.size() == 0) begin
        $error("unexpected result item, command_code %0d", command_code_o);
        fail_count++;
      end else begin
        want = expected_reports.pop_front();
        check_field("step_up", want.step_up, step_up_o);
        check_field("step_down", want.step_down, step_down_o);
        check_field("drive_forward", want.fwd, drive_forward_o);
        check_field("drive_reverse", want.rev, drive_reverse_o);
        check_field("speed_lines", want.lines, speed_lines_o);
        check_field("command_code", want.code, command_code_o);
        check_field("last", want.last, last_o);
        reports_checked++;
      end
    end
  end

  initial begin
    load_words();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_command_words();
    test_odd_text();
    test_output_backpressure();
    test_random_traffic();
    test_closing_burst();
    pause_until_drained();
    repeat (SETTLE_WAIT) @(posedge clk_i);
    $display("Checked %0d result items from %0d commands (%0d unrecognized, %0d speed steps).",
             reports_checked, commands_seen, unknown_seen, steps_seen);
    $display("Characters taken: %0d; longest output hold-off: %0d cycles.",
             bytes_taken, longest_hold);
    if (fail_count == 0 && expected_reports.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #10_000_000;
    $display("Timeout with %0d result items outstanding", expected_reports.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
